[design/modular_exponentiation_macros.svh]
// ---------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Shared concurrent assertion wrappers; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

`ifndef SYNTH
// condition holds at every edge outside reset
`define MEXP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// consequent holds in the same cycle as the antecedent
`define MEXP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// consequent holds in the cycle after the antecedent
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MEXP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define MEXP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[design/mexp_pkg.sv]
// ---------------------------------------------------------------------------
// Modular exponentiation package
// Widths, datapath command codes and controller/datapath link types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

    // fixed field width on the stream words
    localparam int FIELD_BITS = 32;
    // default arithmetic width
    localparam int OPERAND_BITS_DEF = 32;

    // datapath operations
    localparam logic [2:0] OP_NONE       = 3'd0;
    localparam logic [2:0] OP_LOAD       = 3'd1;
    localparam logic [2:0] OP_REDUCE     = 3'd2;
    localparam logic [2:0] OP_START_PROD = 3'd3;
    localparam logic [2:0] OP_START_SQR  = 3'd4;
    localparam logic [2:0] OP_STEP_PROD  = 3'd5;
    localparam logic [2:0] OP_STEP_SQR   = 3'd6;
    localparam logic [2:0] OP_OUT        = 3'd7;

    // result source for the output word
    localparam logic [1:0] RES_PROD = 2'd0;
    localparam logic [1:0] RES_ONE  = 2'd1;
    localparam logic [1:0] RES_ERR  = 2'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] res_sel;
    } t_cmd;

    typedef struct packed {
        logic mod_zero;
        logic exp_zero;
        logic exp_lsb;
        logic exp_rest_zero;
        logic cnt_last;
    } t_status;

endpackage

`default_nettype wire

[design/modular_exponentiation.sv]
// Modular exponentiation, right-to-left square-and-multiply.
// Input stream: one word holds base, exponent and modulus; accepted when
// i_s_axis_tvalid and o_s_axis_tready are both high. Output stream: one word
// per input with the power and, in tuser, the zero-modulus error flag.
// One item is worked at a time; o_s_axis_tready is high only while the
// engine is idle. A finished result sits in the output register, so the
// next item is taken while that result waits for i_m_axis_tready.
// A zero modulus or zero exponent skips the arithmetic; otherwise the base
// is first reduced bit-serially, then each set exponent bit gets a multiply
// and every bit below the top set bit gets a square, the multiply and the
// square both running in the single bit-serial modular multiplier.
// A stalled receiver holds the result in the output register;
// the engine then finishes its next item and waits until the register frees.
// Reset (synchronous, active low) returns the engine to idle and drops any
// pending result.
// ---------------------------------------------------------------------------
// Modular exponentiation top level
// Stream wrapper joining the controller and the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // base_value [31:0], exponent_value [63:32], modulus_value [95:64]
    input  wire logic [3*FIELD_BITS-1:0]   i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  wire logic                      i_m_axis_tready,
    // power_result [31:0]
    output logic [FIELD_BITS-1:0]          o_m_axis_tdata,
    // modulus_error [0]
    output logic                           o_m_axis_tuser
);

    t_cmd    cmd;
    t_status status;

    mexp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mexp_dpath #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_base          (i_s_axis_tdata[FIELD_BITS-1:0]),
        .i_exponent      (i_s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]),
        .i_modulus       (i_s_axis_tdata[3*FIELD_BITS-1:2*FIELD_BITS]),
        .o_status        (status),
        .o_power_result  (o_m_axis_tdata),
        .o_modulus_error (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

[design/mexp_dpath.sv]
// ---------------------------------------------------------------------------
// Modular exponentiation datapath
// Operand registers, bit-serial modular reducer and multiplier, output word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "modular_exponentiation_macros.svh"

module mexp_dpath
    import mexp_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    input  wire logic [FIELD_BITS-1:0] i_base,
    input  wire logic [FIELD_BITS-1:0] i_exponent,
    input  wire logic [FIELD_BITS-1:0] i_modulus,
    output t_status                    o_status,
    output logic [FIELD_BITS-1:0]      o_power_result,
    output logic                       o_modulus_error
);

    localparam int W  = OPERAND_BITS;
    localparam int DW = (W > FIELD_BITS) ? W : FIELD_BITS;
    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]  r_base;
    logic [W-1:0]  r_src;
    logic [W-1:0]  r_exp;
    logic [W-1:0]  r_mod;
    logic [W-1:0]  r_prod;
    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_mult;
    logic [CW-1:0] r_cnt;
    logic [FIELD_BITS-1:0] r_out_data;
    logic                  r_out_err;

    logic [DW-1:0] base_ext;
    logic [DW-1:0] exp_ext;
    logic [DW-1:0] mod_ext;
    logic [DW-1:0] prod_ext;
    logic [W-1:0]  base_in;
    logic [W-1:0]  exp_in;
    logic [W-1:0]  mod_in;
    logic [W:0]    rem_t;
    logic [W-1:0]  rem_res;
    logic [W+1:0]  mul_t;
    logic [W+1:0]  mul_m1;
    logic [W+1:0]  mul_m2;
    logic [W+1:0]  mul_sel;
    logic [W-1:0]  mul_res;
    logic          cnt_last;

    // take the low operand bits of each field
    assign base_ext = DW'(i_base);
    assign exp_ext  = DW'(i_exponent);
    assign mod_ext  = DW'(i_modulus);
    assign base_in  = base_ext[W-1:0];
    assign exp_in   = exp_ext[W-1:0];
    assign mod_in   = mod_ext[W-1:0];
    assign prod_ext = DW'(r_prod);

    assign cnt_last = (r_cnt == CW'(W - 1));

    // reduction step: shift one base bit into the remainder, subtract once
    always_comb begin
        rem_t = {r_base, r_src[W-1]};
        if (rem_t >= {1'b0, r_mod}) begin
            rem_res = W'(rem_t - {1'b0, r_mod});
        end else begin
            rem_res = rem_t[W-1:0];
        end
    end

    // multiply step: double the accumulator, add x on a set multiplier bit
    always_comb begin
        mul_m1 = {2'b00, r_mod};
        mul_m2 = {1'b0, r_mod, 1'b0};
        mul_t  = {1'b0, r_acc, 1'b0} + (r_mult[W-1] ? {2'b00, r_x} : '0);
        if (mul_t >= mul_m2) begin
            mul_sel = mul_t - mul_m2;
        end else if (mul_t >= mul_m1) begin
            mul_sel = mul_t - mul_m1;
        end else begin
            mul_sel = mul_t;
        end
        mul_res = mul_sel[W-1:0];
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD, OP_START_PROD, OP_START_SQR: r_cnt <= '0;
                OP_REDUCE, OP_STEP_SQR:               r_cnt <= cnt_last ? '0 : r_cnt + 1'b1;
                OP_STEP_PROD:                         r_cnt <= cnt_last ? '0 : r_cnt + 1'b1;
                default:                              r_cnt <= r_cnt;
            endcase
        end
    end

    // operand and working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_base <= '0;
                r_src  <= base_in;
                r_exp  <= exp_in;
                r_mod  <= mod_in;
                r_prod <= (mod_in == W'(1)) ? '0 : W'(1);
            end
            OP_REDUCE: begin
                r_base <= rem_res;
                r_src  <= {r_src[W-2:0], 1'b0};
            end
            OP_START_PROD: begin
                r_acc  <= '0;
                r_x    <= r_base;
                r_mult <= r_prod;
            end
            OP_START_SQR: begin
                r_acc  <= '0;
                r_x    <= r_base;
                r_mult <= r_base;
            end
            OP_STEP_PROD: begin
                // on the last step store the product and set up the square
                if (cnt_last) begin
                    r_prod <= mul_res;
                    r_acc  <= '0;
                    r_x    <= r_base;
                    r_mult <= r_base;
                end else begin
                    r_acc  <= mul_res;
                    r_mult <= {r_mult[W-2:0], 1'b0};
                end
            end
            OP_STEP_SQR: begin
                if (cnt_last) begin
                    r_base <= mul_res;
                    r_exp  <= {1'b0, r_exp[W-1:1]};
                end else begin
                    r_acc  <= mul_res;
                    r_mult <= {r_mult[W-2:0], 1'b0};
                end
            end
            OP_OUT: begin
                unique case (i_cmd.res_sel)
                    RES_PROD: begin
                        r_out_data <= prod_ext[FIELD_BITS-1:0];
                        r_out_err  <= 1'b0;
                    end
                    RES_ONE: begin
                        r_out_data <= FIELD_BITS'(1);
                        r_out_err  <= 1'b0;
                    end
                    default: begin
                        r_out_data <= '0;
                        r_out_err  <= 1'b1;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    assign o_status.mod_zero      = (r_mod == '0);
    assign o_status.exp_zero      = (r_exp == '0);
    assign o_status.exp_lsb       = r_exp[0];
    assign o_status.exp_rest_zero = (r_exp[W-1:1] == '0);
    assign o_status.cnt_last      = cnt_last;

    assign o_power_result  = r_out_data;
    assign o_modulus_error = r_out_err;

    `MEXP_ASSERT_IMPL(a_acc_reduced, i_clk, i_rst_n,
        (i_cmd.op == OP_STEP_PROD) || (i_cmd.op == OP_STEP_SQR),
        (r_acc < r_mod) && (r_x < r_mod), "multiplier operand not reduced")
    `MEXP_ASSERT_IMPL(a_base_reduced, i_clk, i_rst_n,
        (i_cmd.op == OP_START_PROD) || (i_cmd.op == OP_START_SQR),
        (r_base < r_mod) && (r_prod < r_mod), "base or product not reduced")

endmodule

`default_nettype wire

[design/mexp_ctrl.sv]
// ---------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences load, reduction, square-and-multiply rounds and output hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "modular_exponentiation_macros.svh"

module mexp_ctrl
    import mexp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_REDUCE = 3'd2;
    localparam logic [2:0] S_ROUND  = 3'd3;
    localparam logic [2:0] S_MULP   = 3'd4;
    localparam logic [2:0] S_MULS   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic [1:0] r_sel;
    logic [1:0] n_sel;

    // next state and datapath command
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_sel       = r_sel;
        o_cmd.op      = OP_NONE;
        o_cmd.res_sel = r_sel;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_status.mod_zero) begin
                    n_sel   = RES_ERR;
                    n_state = S_DONE;
                end else if (i_status.exp_zero) begin
                    n_sel   = RES_ONE;
                    n_state = S_DONE;
                end else begin
                    n_sel   = RES_PROD;
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.op = OP_REDUCE;
                if (i_status.cnt_last) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (i_status.exp_lsb) begin
                    o_cmd.op = OP_START_PROD;
                    n_state  = S_MULP;
                end else begin
                    o_cmd.op = OP_START_SQR;
                    n_state  = S_MULS;
                end
            end
            S_MULP: begin
                o_cmd.op = OP_STEP_PROD;
                if (i_status.cnt_last) begin
                    n_state = i_status.exp_rest_zero ? S_DONE : S_MULS;
                end
            end
            S_MULS: begin
                o_cmd.op = OP_STEP_SQR;
                if (i_status.cnt_last) begin
                    n_state = S_ROUND;
                end
            end
            S_DONE: begin
                // hand over once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sel       <= RES_PROD;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_sel       <= n_sel;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `MEXP_ASSERT_NEXT(a_accept_to_check, i_clk, i_rst_n,
        i_in_valid && o_in_ready, r_state == S_CHECK, "accepted word not checked")
    `MEXP_ASSERT_NEXT(a_valid_from_done, i_clk, i_rst_n,
        !r_out_valid || i_out_ready,
        !r_out_valid || ($past(r_state) == S_DONE), "result raised outside hand-off")
    `MEXP_ASSERT_IMPL(a_mul_has_exp, i_clk, i_rst_n,
        (r_state == S_MULP) || (r_state == S_MULS) || (r_state == S_ROUND),
        !i_status.exp_zero && !i_status.mod_zero, "round with no exponent bits left")

endmodule

`default_nettype wire

[verif/tb_modular_exponentiation.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modular exponentiation testbench
// Streams base/exponent/modulus words into the block, predicts each power
// with a square-and-multiply on 64-bit products and checks every returned
// word in order. Both stream sides idle at random, with quiet stretches.
// ---------------------------------------------------------------------------

module tb_modular_exponentiation;
    import mexp_pkg::*;

    localparam int  W           = OPERAND_BITS_DEF;
    // worst item: base reduction plus every exponent bit multiplied and squared
    localparam int  WORST_ITEM  = 3 + W + W * (1 + 2 * W);
    localparam int  DRAIN_WAIT  = WORST_ITEM + 100;
    localparam int  CYCLE_LIMIT = 2500000;
    localparam int  RANDOM_ITEMS = 280;

    typedef logic [FIELD_BITS-1:0] t_operand;

    typedef struct packed {
        t_operand power;
        logic     mod_err;
    } t_power_word;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_valid = 1'b0;
    logic [3*FIELD_BITS-1:0] s_data = '0;
    logic                    m_ready = 1'b0;
    logic                    o_s_axis_tready;
    logic                    o_m_axis_tvalid;
    logic [FIELD_BITS-1:0]   o_m_axis_tdata;
    logic                    o_m_axis_tuser;

    t_power_word expected_powers[$];
    int          error_count = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    longint      cycle_count = 0;
    bit          steady_flow = 1'b0;

    modular_exponentiation dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        // base_value [31:0], exponent_value [63:32], modulus_value [95:64]
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        // power_result [31:0]
        .o_m_axis_tdata  (o_m_axis_tdata),
        // modulus_error [0]
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Right-to-left square-and-multiply; products fit in 64 bits
    function automatic t_power_word predict_power(t_operand b, t_operand e, t_operand m);
        t_power_word      r;
        logic [63:0]      modu;
        logic [63:0]      acc;
        logic [63:0]      sq;
        t_operand         bits;
        r.power   = '0;
        r.mod_err = 1'b0;
        if (m == '0) begin
            r.mod_err = 1'b1;
            return r;
        end
        if (e == '0) begin
            r.power = FIELD_BITS'(1);
            return r;
        end
        modu = 64'(m);
        sq   = 64'(b) % modu;
        acc  = 64'd1 % modu;
        bits = e;
        while (bits != '0) begin
            if (bits[0]) begin
                acc = (acc * sq) % modu;
            end
            bits = bits >> 1;
            if (bits != '0) begin
                sq = (sq * sq) % modu;
            end
        end
        r.power = acc[FIELD_BITS-1:0];
        return r;
    endfunction

    // Mostly no idling, a share of short pauses and a few long ones
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(15, 80);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    // Present one word after an optional gap; return once it is taken
    task automatic send_operands(input t_operand b, input t_operand e, input t_operand m);
        int gap;
        gap = pick_idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {m, e, b};
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_powers.push_back(predict_power(b, e, m));
        words_sent++;
    endtask

    // Receiver back-pressure: random stalls, none in steady stretches
    initial begin : sink_ready
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 7) == 0) begin
                    stall_left = pick_idle_len();
                end
            end
        end
    end

    // Check each output word against the oldest prediction
    always @(posedge i_clk) begin
        t_power_word want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (expected_powers.size() == 0) begin
                report_mismatch($sformatf("unexpected word power=%h err=%b",
                                          o_m_axis_tdata, o_m_axis_tuser));
            end else begin
                want = expected_powers.pop_front();
                if (o_m_axis_tdata !== want.power) begin
                    report_mismatch($sformatf("word %0d power got %h want %h",
                                              words_checked, o_m_axis_tdata, want.power));
                end
                if (o_m_axis_tuser !== want.mod_err) begin
                    report_mismatch($sformatf("word %0d error flag got %b want %b",
                                              words_checked, o_m_axis_tuser, want.mod_err));
                end
            end
            words_checked++;
        end
    end

    // Hard stop on a hang
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_modular_exponentiation: errors");
            $finish;
        end
    end

    // Zero modulus flags an error whatever the exponent
    task automatic test_zero_modulus();
        send_operands(32'd5, 32'd3, 32'd0);
        send_operands(32'd0, 32'd0, 32'd0);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    endtask

    // Zero exponent gives one, left unreduced
    task automatic test_zero_exponent();
        send_operands(32'd7, 32'd0, 32'd13);
        send_operands(32'hFFFF_FFFF, 32'd0, 32'd1);
        send_operands(32'd0, 32'd0, 32'hFFFF_FFFF);
    endtask

    // Modulus of one collapses every power to zero
    task automatic test_unit_modulus();
        send_operands(32'hFFFF_FFFF, 32'd1, 32'd1);
        send_operands(32'd0, 32'd5, 32'd1);
        send_operands(32'd9, 32'hFFFF_FFFF, 32'd1);
    endtask

    // Full-width operands, base at or above modulus, single-bit exponents
    task automatic test_operand_extremes();
        send_operands(32'd0, 32'd1, 32'hFFFF_FFFF);
        send_operands(32'd0, 32'hFFFF_FFFF, 32'd7);
        send_operands(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_operands(32'hFFFF_FFFA, 32'd2, 32'hFFFF_FFFB);
        send_operands(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operands(32'd3, 32'hFFFF_FFFF, 32'd2);
        send_operands(32'd12345, 32'd1, 32'd100);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0001);
        send_operands(32'd2, 32'h8000_0000, 32'hFFFF_FFFB);
        send_operands(32'h8000_0000, 32'd3, 32'h8000_0000);
    endtask

    // Random operands; mostly short exponents to keep the run brisk
    task automatic test_random_operands(input int count);
        t_operand b;
        t_operand e;
        t_operand m;
        int       kind;
        int       len;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                steady_flow = ($urandom_range(0, 4) == 0);
            end
            kind = $urandom_range(0, 99);
            b = $urandom;
            m = $urandom;
            if (kind < 5) begin
                m = '0;
            end else if (kind < 30) begin
                m = $urandom_range(1, 300);
            end
            if ($urandom_range(0, 9) == 0) begin
                b = '0;
            end
            kind = $urandom_range(0, 99);
            if (kind < 5) begin
                e = '0;
            end else if (kind < 35) begin
                e = $urandom;
            end else begin
                len = $urandom_range(1, 12);
                e = ($urandom & ((32'h1 << len) - 1)) | (32'h1 << (len - 1));
            end
            send_operands(b, e, m);
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_modulus();
        test_zero_exponent();
        test_unit_modulus();
        test_operand_extremes();
        test_random_operands(RANDOM_ITEMS);

        @(negedge i_clk);
        s_valid <= 1'b0;

        // drain, then watch a while for stray words
        while (expected_powers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb_modular_exponentiation: clean");
        end else begin
            $display("tb_modular_exponentiation: errors");
        end
        $finish;
    end

endmodule
